[rtl/core/gtod_pkg.sv]
// Shared types and constants for the GPS-synced time-of-day clock.
// No dependencies; imported by the interfaces and all core modules.
package gtod_pkg;

  localparam int unsigned MS_PER_SEC      = 1000;
  localparam int unsigned SEC_PER_MIN     = 60;
  localparam int unsigned MIN_PER_HOUR    = 60;
  localparam int unsigned HOURS_PER_DAY   = 24;
  localparam int unsigned HOURS_HALF_DAY  = 12;
  localparam int unsigned SINCE_MAX       = 65535;

  localparam int unsigned MS_W      = 10;
  localparam int unsigned SINCE_W   = 16;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned HOUR12_W  = 4;
  localparam int unsigned MIN_W     = 6;
  localparam int unsigned SEC_W     = 6;
  localparam int unsigned OFFSET_W  = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset time of day is 10:10:00.
  localparam logic [HOUR_W-1:0] RESET_HOUR   = HOUR_W'(10);
  localparam logic [MIN_W-1:0]  RESET_MINUTE = MIN_W'(10);
  localparam logic [SEC_W-1:0]  RESET_SECOND = SEC_W'(0);
  localparam logic [SINCE_W-1:0] RESET_RESYNC = SINCE_W'(60000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZONE_SHIFT = 1'b0,
    REG_RESYNC     = 1'b1
  } cfg_reg_t;

  // Time of day as separate hour / minute / second fields.
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } hms_t;

endpackage

[rtl/core/gtod_if.sv]
// Channel interfaces: tick input, time result output, config write.
// Depends on gtod_pkg.
interface gtod_tick_if import gtod_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              time_report;
  logic [HOUR_W-1:0] report_hour;
  logic [MIN_W-1:0]  report_minute;
  logic [SEC_W-1:0]  report_second;

  modport source (output valid, time_report, report_hour, report_minute, report_second,
                  input ready);
  modport sink   (input valid, time_report, report_hour, report_minute, report_second,
                  output ready);
endinterface

interface gtod_result_if import gtod_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HOUR_W-1:0]   hour_24;
  logic [HOUR12_W-1:0] hour_12;
  logic [MIN_W-1:0]    minute_now;
  logic [SEC_W-1:0]    second_now;
  logic                is_synced;

  modport source (output valid, hour_24, hour_12, minute_now, second_now, is_synced,
                  input ready);
  modport sink   (input valid, hour_24, hour_12, minute_now, second_now, is_synced,
                  output ready);
endinterface

interface gtod_cfg_if import gtod_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[rtl/core/gps_synced_time_of_day_clock.sv]
// Top level of the GPS-synced time-of-day clock: tick handling, config, result.
// Depends on gtod_pkg, gtod_if (channel interfaces) and gtod_load.
//
//   channel  dir  beat payload
//   -------  ---  ---------------------------------------------------------
//   tick     in   time_report, report_hour, report_minute, report_second
//   result   out  hour_24, hour_12, minute_now, second_now, is_synced
//   cfg      in   reg_index (0 utc offset, 1 resync interval), wr_data
//
// One tick per cycle while the result is not stalled; each tick's result appears in the cycle after acceptance.
// The time state and the result valid are updated in a single register stage.
// A stalled result blocks ticks only while it is held; taking it frees tick.ready
// in the same cycle. cfg is always ready.
// Reset (synchronous): time 10:10:00, unsynced, offset 0, resync interval 60000.
module gps_synced_time_of_day_clock import gtod_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  gtod_tick_if.sink      tick,
  gtod_result_if.source  result,
  gtod_cfg_if.sink       cfg
);

  logic signed [OFFSET_W-1:0] zone_shift;
  logic [SINCE_W-1:0]         resync_interval;

  logic [MS_W-1:0]    ms_phase;
  logic [MS_W-1:0]    ms_phase_next;
  hms_t               now;
  hms_t               now_next;
  hms_t               tick_time;
  hms_t               report_time;
  logic [SINCE_W-1:0] ms_since_sync;
  logic [SINCE_W-1:0] since_inc;
  logic [SINCE_W-1:0] ms_since_sync_next;
  logic               synced;
  logic               do_sync;
  logic               out_valid;
  logic               tick_fire;
  logic               sec_wrap;
  logic               min_wrap;

  assign tick.ready = !out_valid || result.ready;
  assign tick_fire  = tick.valid && tick.ready;
  assign cfg.ready  = 1'b1;

  gtod_load u_load (
    .report_hour   (tick.report_hour),
    .report_minute (tick.report_minute),
    .report_second (tick.report_second),
    .zone_shift    (zone_shift),
    .local_time    (report_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_shift      <= '0;
      resync_interval <= RESET_RESYNC;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.reg_index))
        REG_ZONE_SHIFT: zone_shift      <= cfg.wr_data[OFFSET_W-1:0];
        REG_RESYNC:     resync_interval <= cfg.wr_data[SINCE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance by one millisecond, carrying through seconds, minutes, hours; a due time report loads instead.
  always_comb begin
    tick_time = now;
    sec_wrap  = now.second == SEC_W'(SEC_PER_MIN - 1);
    min_wrap  = now.minute == MIN_W'(MIN_PER_HOUR - 1);
    if (ms_phase == MS_W'(MS_PER_SEC - 1)) begin
      ms_phase_next    = '0;
      tick_time.second = sec_wrap ? '0 : now.second + SEC_W'(1);
      if (sec_wrap) begin
        tick_time.minute = min_wrap ? '0 : now.minute + MIN_W'(1);
        if (min_wrap) begin
          tick_time.hour = (now.hour == HOUR_W'(HOURS_PER_DAY - 1)) ? '0
                                                                    : now.hour + HOUR_W'(1);
        end
      end
    end else begin
      ms_phase_next = ms_phase + MS_W'(1);
    end

    since_inc = (ms_since_sync == SINCE_W'(SINCE_MAX)) ? ms_since_sync
                                                       : ms_since_sync + SINCE_W'(1);
    do_sync = tick.time_report && (!synced || since_inc > resync_interval);

    now_next           = do_sync ? report_time : tick_time;
    ms_since_sync_next = do_sync ? '0 : since_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_phase      <= '0;
      now.hour      <= RESET_HOUR;
      now.minute    <= RESET_MINUTE;
      now.second    <= RESET_SECOND;
      ms_since_sync <= '0;
      synced        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (tick_fire) begin
        ms_phase      <= do_sync ? '0 : ms_phase_next;
        now           <= now_next;
        ms_since_sync <= ms_since_sync_next;
        synced        <= synced || do_sync;
        out_valid     <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // State only moves on an accepted tick, so the result reads it directly.
  assign result.valid      = out_valid;
  assign result.hour_24    = now.hour;
  assign result.hour_12    = (now.hour >= HOUR_W'(HOURS_HALF_DAY))
                             ? HOUR12_W'(now.hour - HOUR_W'(HOURS_HALF_DAY))
                             : HOUR12_W'(now.hour);
  assign result.minute_now = now.minute;
  assign result.second_now = now.second;
  assign result.is_synced  = synced;

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (now.hour < HOUR_W'(HOURS_PER_DAY)) && (now.minute < MIN_W'(MIN_PER_HOUR))
    && (now.second < SEC_W'(SEC_PER_MIN)))
    else $error("time of day out of range");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    ms_phase < MS_W'(MS_PER_SEC))
    else $error("millisecond phase out of range");

  a_sync_clears: assert property (@(posedge clk) disable iff (rst)
    (tick_fire && do_sync) |=> (ms_since_sync == '0) && (ms_phase == '0) && synced)
    else $error("sync did not load the clock");

  a_synced_sticky: assert property (@(posedge clk) disable iff (rst)
    synced |=> synced)
    else $error("synced flag dropped");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !tick_fire |=> $stable(now) && $stable(ms_since_sync))
    else $error("time changed without a tick");

endmodule

[rtl/core/gtod_load.sv]
// Converts a GPS report plus UTC offset into a normalized local time of day.
// Depends on gtod_pkg.
module gtod_load import gtod_pkg::*; (
  input  logic [HOUR_W-1:0]          report_hour,
  input  logic [MIN_W-1:0]           report_minute,
  input  logic [SEC_W-1:0]           report_second,
  input  logic signed [OFFSET_W-1:0] zone_shift,
  output hms_t                       local_time
);

  localparam int unsigned HS_W = 7;

  logic [HS_W-1:0]    hs;
  logic [HS_W-1:0]    hs_a;
  logic [HS_W-1:0]    hs_b;
  logic [HS_W-1:0]    hs_c;
  logic               sec_carry;
  logic [MIN_W:0]     min_sum;
  logic               min_carry;
  logic [HOUR_W-1:0]  hour_sum;

  // Bias by two days so the sum stays positive: 16..110.
  assign hs = HS_W'(report_hour) + HS_W'(2 * HOURS_PER_DAY)
              + HS_W'(signed'({{(HS_W-OFFSET_W){zone_shift[OFFSET_W-1]}}, zone_shift}));

  // Modulo 24 by three compare-subtract steps.
  assign hs_a = (hs   >= HS_W'(4 * HOURS_PER_DAY)) ? hs   - HS_W'(4 * HOURS_PER_DAY) : hs;
  assign hs_b = (hs_a >= HS_W'(2 * HOURS_PER_DAY)) ? hs_a - HS_W'(2 * HOURS_PER_DAY) : hs_a;
  assign hs_c = (hs_b >= HS_W'(HOURS_PER_DAY))     ? hs_b - HS_W'(HOURS_PER_DAY)     : hs_b;

  // Seconds and minutes up to 63 carry into the next field.
  assign sec_carry = report_second >= SEC_W'(SEC_PER_MIN);
  assign min_sum   = (MIN_W+1)'(report_minute) + (MIN_W+1)'(sec_carry);
  assign min_carry = min_sum >= (MIN_W+1)'(MIN_PER_HOUR);
  assign hour_sum  = hs_c[HOUR_W-1:0] + HOUR_W'(min_carry);

  always_comb begin
    local_time.second = sec_carry ? report_second - SEC_W'(SEC_PER_MIN) : report_second;
    local_time.minute = min_carry ? MIN_W'(min_sum - (MIN_W+1)'(MIN_PER_HOUR))
                                  : min_sum[MIN_W-1:0];
    local_time.hour   = (hour_sum == HOUR_W'(HOURS_PER_DAY)) ? '0 : hour_sum;
  end

endmodule
